// File: rtl/ffha_pkg.sv
// shared types, codes and defaults for the first-fit heap allocator
package ffha_pkg;

   localparam int ARENA_BYTES_DEF  = 256;
   localparam int HEADER_BYTES_DEF = 25;
   localparam int MAX_BLOCKS_DEF   = 16;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int OP_W     = 3;

   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [OP_W-1:0]     op_type;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NO_SPACE  = 2'd1;
   localparam status_type ST_ZERO_SIZE = 2'd2;
   localparam status_type ST_NOT_FOUND = 2'd3;

   localparam logic ACT_ALLOC   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   // datapath operations issued by the controller
   localparam op_type OP_NONE       = 3'd0;
   localparam op_type OP_LOAD       = 3'd1;
   localparam op_type OP_STEP       = 3'd2;
   localparam op_type OP_GRANT      = 3'd3;
   localparam op_type OP_FREE       = 3'd4;
   localparam op_type OP_MERGE_NEXT = 3'd5;
   localparam op_type OP_MERGE_PREV = 3'd6;

   typedef struct packed {
      byte_type offset;
      byte_type size;
      logic     used;
   } entry_type;

   typedef struct packed {
      op_type     op;
      logic       respond;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic is_release;
      logic zero_size;
      logic at_end;
      logic fits;
      logic addr_hit;
      logic next_free;
      logic prev_free;
   } stat_type;

endpackage

// File: rtl/ffha_ctrl.sv
// controller state machine: walks the block table and sequences split and merge steps
module ffha_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ffha_pkg::stat_type stat,
   output ffha_pkg::cmd_type  cmd
);
   import ffha_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_GRANT = 3'd2;
   localparam logic [2:0] S_NEXT  = 3'd3;
   localparam logic [2:0] S_PREV  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.op      = OP_NONE;
      cmd.respond = 1'b0;
      cmd.status  = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            priority if (!stat.is_release && stat.zero_size) begin
               cmd.respond = 1'b1;
               cmd.status  = ST_ZERO_SIZE;
               state_in    = S_IDLE;
            end else if (stat.at_end) begin
               cmd.respond = 1'b1;
               cmd.status  = stat.is_release ? ST_NOT_FOUND : ST_NO_SPACE;
               state_in    = S_IDLE;
            end else if (!stat.is_release && stat.fits) begin
               // hold the index; the split math runs next cycle
               state_in = S_GRANT;
            end else if (stat.is_release && stat.addr_hit) begin
               cmd.op   = OP_FREE;
               state_in = S_NEXT;
            end else begin
               cmd.op = OP_STEP;
            end
         end
         S_GRANT: begin
            cmd.op      = OP_GRANT;
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         S_NEXT: begin
            if (stat.next_free) begin
               cmd.op = OP_MERGE_NEXT;
            end
            state_in = S_PREV;
         end
         S_PREV: begin
            if (stat.prev_free) begin
               cmd.op = OP_MERGE_PREV;
            end
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: rtl/ffha_dpath.sv
// datapath: block table, walk index, split and merge arithmetic, result register
module ffha_dpath #(
   parameter int ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
   parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_action,
   input  ffha_pkg::byte_type   req_request_size,
   input  ffha_pkg::byte_type   req_release_address,
   input  ffha_pkg::cmd_type    cmd,
   output ffha_pkg::stat_type   stat,
   output logic                 rsp_valid,
   output ffha_pkg::status_type rsp_status,
   output ffha_pkg::byte_type   rsp_address
);
   import ffha_pkg::*;

   localparam int IDX_W = $clog2(MAX_BLOCKS + 1);
   localparam byte_type HDR       = BYTE_W'(HEADER_BYTES);
   localparam byte_type INIT_SIZE = BYTE_W'(ARENA_BYTES - HEADER_BYTES);
   localparam logic [IDX_W-1:0] MAX_CNT = IDX_W'(MAX_BLOCKS);
   localparam logic [IDX_W-1:0] ONE     = IDX_W'(1);

   entry_type        tbl_ff [MAX_BLOCKS];
   entry_type        tbl_in [MAX_BLOCKS];
   entry_type        shl    [MAX_BLOCKS];
   entry_type        shr    [MAX_BLOCKS];
   logic [IDX_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] hit_ff;
   entry_type        prev_ff;
   byte_type         cur_ff;
   logic             act_ff;
   byte_type         size_ff;
   byte_type         addr_ff;
   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   byte_type         rsp_address_ff;

   entry_type rd;
   byte_type  rest;
   logic      split;
   byte_type  new_off;
   byte_type  new_size;
   byte_type  next_sum;
   byte_type  prev_sum;

   // single read port at the walk index
   always_comb begin
      rd = '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         if (idx_ff == IDX_W'(i)) begin
            rd = tbl_ff[i];
         end
      end
   end

   // neighbor views of the table for insert and remove
   always_comb begin
      for (int i = 0; i < MAX_BLOCKS - 1; i++) begin
         shl[i] = tbl_ff[i + 1];
      end
      shl[MAX_BLOCKS-1] = '0;
      shr[0] = '0;
      for (int i = 1; i < MAX_BLOCKS; i++) begin
         shr[i] = tbl_ff[i - 1];
      end
   end

   assign rest     = rd.size - size_ff;
   assign split    = (rest > HDR) && (count_ff < MAX_CNT);
   assign new_off  = byte_type'(rd.offset + size_ff + HDR);
   assign new_size = rest - HDR;
   assign next_sum = byte_type'(cur_ff + rd.size + HDR);
   assign prev_sum = byte_type'(prev_ff.size + cur_ff + HDR);

   assign stat.is_release = (act_ff == ACT_RELEASE);
   assign stat.zero_size  = (size_ff == '0);
   assign stat.at_end     = (idx_ff >= count_ff);
   assign stat.fits       = !rd.used && (rd.size >= size_ff);
   assign stat.addr_hit   = (rd.offset == addr_ff);
   assign stat.next_free  = (idx_ff < count_ff) && !rd.used;
   assign stat.prev_free  = (hit_ff != '0) && !prev_ff.used;

   always_comb begin
      tbl_in   = tbl_ff;
      count_in = count_ff;
      unique case (cmd.op)
         OP_GRANT: begin
            for (int i = 0; i < MAX_BLOCKS; i++) begin
               if (IDX_W'(i) == idx_ff) begin
                  tbl_in[i].used = 1'b1;
                  if (split) begin
                     tbl_in[i].size = size_ff;
                  end
               end else if (split && (IDX_W'(i) == idx_ff + ONE)) begin
                  tbl_in[i].offset = new_off;
                  tbl_in[i].size   = new_size;
                  tbl_in[i].used   = 1'b0;
               end else if (split && (IDX_W'(i) > idx_ff + ONE)) begin
                  tbl_in[i] = shr[i];
               end
            end
            if (split) begin
               count_in = count_ff + ONE;
            end
         end
         OP_FREE: begin
            for (int i = 0; i < MAX_BLOCKS; i++) begin
               if (IDX_W'(i) == idx_ff) begin
                  tbl_in[i].used = 1'b0;
               end
            end
         end
         OP_MERGE_NEXT: begin
            // successor sits at the walk index, freed block at the hit index
            for (int i = 0; i < MAX_BLOCKS; i++) begin
               if (IDX_W'(i) >= idx_ff) begin
                  tbl_in[i] = shl[i];
               end else if (IDX_W'(i) == hit_ff) begin
                  tbl_in[i].size = next_sum;
               end
            end
            count_in = count_ff - ONE;
         end
         OP_MERGE_PREV: begin
            for (int i = 0; i < MAX_BLOCKS; i++) begin
               if (IDX_W'(i) >= hit_ff) begin
                  tbl_in[i] = shl[i];
               end else if (IDX_W'(i) + ONE == hit_ff) begin
                  tbl_in[i].size = prev_sum;
               end
            end
            count_in = count_ff - ONE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i < MAX_BLOCKS; i++) begin
            tbl_ff[i] <= '0;
         end
         tbl_ff[0]    <= '{offset: HDR, size: INIT_SIZE, used: 1'b0};
         count_ff     <= ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         tbl_ff       <= tbl_in;
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            act_ff  <= req_action;
            size_ff <= req_request_size;
            addr_ff <= req_release_address;
            idx_ff  <= '0;
            prev_ff <= '0;
         end
         OP_STEP: begin
            prev_ff <= rd;
            idx_ff  <= idx_ff + ONE;
         end
         OP_FREE: begin
            hit_ff <= idx_ff;
            cur_ff <= rd.size;
            idx_ff <= idx_ff + ONE;
         end
         OP_MERGE_NEXT: begin
            cur_ff <= next_sum;
         end
         default: begin
         end
      endcase
      if (cmd.respond) begin
         rsp_status_ff <= cmd.status;
         if (cmd.status != ST_OK) begin
            rsp_address_ff <= '0;
         end else if (act_ff == ACT_RELEASE) begin
            rsp_address_ff <= addr_ff;
         end else begin
            rsp_address_ff <= rd.offset;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_address = rsp_address_ff;

endmodule

// File: rtl/first_fit_heap_allocator.sv
// top level of the first-fit heap allocator with split and coalesce
//
//  channel   ports                                         transfer when
//  request   start, busy, req_action, req_request_size,    start && !busy
//            req_release_address
//  response  rsp_valid, rsp_status, rsp_address            rsp_valid (one cycle)
//
// the controller walks the block table one entry per cycle through a single read port.
// an allocate answers after the scan and a grant step, a release after the free and
// both merge steps, a miss after a full walk, a zero size is refused at the first scan step.
// busy falls in the strobe cycle, so the next request can transfer there.
// synchronous reset restores the arena to one free block; no clearing pass is needed.
// the response cannot be held off: rsp_* are valid for the strobe cycle only.
module first_fit_heap_allocator #(
   parameter int ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
   parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_action,
   input  ffha_pkg::byte_type   req_request_size,
   input  ffha_pkg::byte_type   req_release_address,
   output logic                 rsp_valid,
   output ffha_pkg::status_type rsp_status,
   output ffha_pkg::byte_type   rsp_address
);
   import ffha_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ffha_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ffha_dpath #(
      .ARENA_BYTES  (ARENA_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_BLOCKS   (MAX_BLOCKS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_action          (req_action),
      .req_request_size    (req_request_size),
      .req_release_address (req_release_address),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_address         (rsp_address)
   );

endmodule

// File: rtl/ffha_check.sv
// port-level checks for the first-fit heap allocator, bound to the top level
module ffha_check (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input ffha_pkg::status_type rsp_status,
   input ffha_pkg::byte_type   rsp_address
);
   import ffha_pkg::*;

   // a response closes the request: the block is free again in the strobe cycle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while still busy");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a request in progress");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer did not raise busy");

   a_err_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_address == '0))
      else $error("nonzero address on an error response");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

endmodule

bind first_fit_heap_allocator ffha_check u_ffha_check (.*);
